// ----- sv/cstg_pkg.sv -----
package cstg_pkg;

   localparam int SINE_TABLE_DEPTH_DEFAULT = 1024;
   localparam int PHASE_BITS_DEFAULT       = 32;
   localparam int MAX_BLOCK_FRAMES_DEFAULT = 64;

   localparam logic [31:0] PHASE_INCREMENT_RESET = 32'd39370534;
   localparam logic [16:0] GAIN_RESET            = 17'd32768;
   localparam logic [14:0] CLIP_LIMIT_RESET      = 15'd8192;
   localparam logic [23:0] TOTAL_FRAMES_RESET    = 24'd48000;

   localparam logic [14:0] FULL_SCALE  = 15'd32767;
   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

   typedef enum logic [1:0] {
      CSR_PHASE_INCREMENT,
      CSR_GAIN,
      CSR_CLIP_LIMIT,
      CSR_TOTAL_FRAMES
   } cstg_csr_type;

   typedef enum logic [2:0] {
      ST_FILL,
      ST_IDLE,
      ST_NEXT,
      ST_READ,
      ST_SCALE,
      ST_SHAPE,
      ST_EMIT
   } cstg_state_type;

   typedef struct packed {
      logic        neg;
      logic [14:0] mag;
   } cstg_sine_type;

   // Q30 sine series of a Q30 angle, rounded to unsigned Q0.15 (full scale 32767)
   function automatic logic [14:0] sine_q15(input logic [63:0] x);
      logic [63:0]        x2;
      logic [63:0]        term;
      logic signed [63:0] sum;
      logic [63:0]        v;
      x2   = (x * x) >> 30;
      term = x;
      sum  = $signed(x);
      term = ((term * x2) >> 30) / 64'd6;
      sum  = sum - $signed(term);
      term = ((term * x2) >> 30) / 64'd20;
      sum  = sum + $signed(term);
      term = ((term * x2) >> 30) / 64'd42;
      sum  = sum - $signed(term);
      term = ((term * x2) >> 30) / 64'd72;
      sum  = sum + $signed(term);
      term = ((term * x2) >> 30) / 64'd110;
      sum  = sum - $signed(term);
      if (sum < 0) begin
         sum = 64'sd0;
      end
      v = ($unsigned(sum) * 64'(FULL_SCALE) + (64'd1 << 29)) >> 30;
      if (v > 64'(FULL_SCALE)) begin
         v = 64'(FULL_SCALE);
      end
      return v[14:0];
   endfunction

endpackage

// ----- sv/cstg_ram.sv -----
module cstg_ram #(
   parameter int WIDTH = 15,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- sv/cstg_sine.sv -----
module cstg_sine #(
   parameter int SINE_TABLE_DEPTH = cstg_pkg::SINE_TABLE_DEPTH_DEFAULT,
   parameter int PHASE_BITS       = cstg_pkg::PHASE_BITS_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic [PHASE_BITS-1:0]   phase,
   input  logic                    rd_en,
   output logic                    fill_done,
   output cstg_pkg::cstg_sine_type sine
);
   import cstg_pkg::*;

   localparam int          IndexBits = $clog2(SINE_TABLE_DEPTH + 1) - 1;
   localparam int          Span      = 1 << IndexBits;
   localparam logic [63:0] DepthWide = 64'(SINE_TABLE_DEPTH);

   logic [14:0] rom_w [Span];

   for (genvar k = 0; k < Span; k++) begin : g_rom
      localparam logic [63:0] AngleQ30 = (64'(k) * HALF_PI_Q30) / DepthWide;
      assign rom_w[k] = sine_q15(AngleQ30);
   end

   logic [IndexBits:0]   fill_cnt_ff;
   logic [IndexBits:0]   fill_cnt_in;
   logic                 fill_we_ff;
   logic                 fill_we_in;
   logic                 fill_done_ff;
   logic                 fill_done_in;
   logic [IndexBits-1:0] fill_addr_ff;
   logic [14:0]          fill_data_ff;

   always_comb begin
      fill_cnt_in  = fill_cnt_ff;
      fill_we_in   = 1'b0;
      fill_done_in = fill_done_ff;
      if (fill_cnt_ff != (IndexBits + 1)'(Span)) begin
         fill_cnt_in = fill_cnt_ff + 1'b1;
         fill_we_in  = 1'b1;
      end else begin
         fill_done_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_cnt_ff  <= '0;
         fill_we_ff   <= 1'b0;
         fill_done_ff <= 1'b0;
      end else begin
         fill_cnt_ff  <= fill_cnt_in;
         fill_we_ff   <= fill_we_in;
         fill_done_ff <= fill_done_in;
      end
   end

   always_ff @(posedge clock) begin
      fill_addr_ff <= fill_cnt_ff[IndexBits-1:0];
      fill_data_ff <= rom_w[fill_cnt_ff[IndexBits-1:0]];
   end

   logic [1:0]           quadrant;
   logic [IndexBits-1:0] index;
   logic [IndexBits-1:0] rd_addr;
   logic [14:0]          rd_data;
   logic                 neg_ff;
   logic                 full_ff;

   assign quadrant = phase[PHASE_BITS-1 -: 2];
   assign index    = phase[PHASE_BITS-3 -: IndexBits];
   assign rd_addr  = quadrant[0] ? IndexBits'(~index + 1'b1) : index;

   always_ff @(posedge clock) begin
      if (rd_en) begin
         neg_ff  <= quadrant[1];
         full_ff <= quadrant[0] && (index == '0);
      end
   end

   cstg_ram #(
      .WIDTH (15),
      .DEPTH (Span)
   ) u_ram (
      .clock   (clock),
      .wr_en   (fill_we_ff),
      .wr_addr (fill_addr_ff),
      .wr_data (fill_data_ff),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign fill_done = fill_done_ff;
   assign sine.neg  = neg_ff;
   assign sine.mag  = full_ff ? FULL_SCALE : rd_data;

endmodule

// ----- sv/cstg_scale.sv -----
module cstg_scale (
   input  logic                    clock,
   input  logic                    mul_en,
   input  cstg_pkg::cstg_sine_type sine,
   input  logic [16:0]             gain,
   input  logic [14:0]             clip_limit,
   output logic [15:0]             sample
);
   import cstg_pkg::*;

   logic [31:0] prod_ff;
   logic        neg_ff;
   logic [15:0] scaled;
   logic [14:0] clamped;
   logic [15:0] mag16;

   always_ff @(posedge clock) begin
      if (mul_en) begin
         prod_ff <= {17'd0, sine.mag} * {15'd0, gain};
         neg_ff  <= sine.neg;
      end
   end

   assign scaled  = prod_ff[31:16];
   assign clamped = (scaled > {1'b0, clip_limit}) ? clip_limit : scaled[14:0];
   assign mag16   = {1'b0, clamped};
   assign sample  = neg_ff ? (~mag16 + 16'd1) : mag16;

endmodule

// ----- sv/clipped_sine_tone_generator.sv -----
// Sine tone source with gain and symmetric clipping.
// req channel: one word asks for a block of frames. req_tdata[6:0] is the frame
// count (above the block limit it saturates, zero yields nothing), req_tuser is
// restart, which clears the phase and reloads the tone length first.
// rsp channel: one word per frame. rsp_tdata is the signed sample, rsp_tlast
// marks the last frame of the block, rsp_tuser flags padding and stream end.
// csr channel: csr_index selects phase increment, gain, clip limit or total
// frames; csr_ready is always high. Write it only while the block is idle.
// Steps: a tone frame goes through next, table read, multiply, clamp and
// present, a padding frame through next and present, each waiting on any rsp
// stall. req_tready stays low until the last frame of a block is taken, so no
// new block is accepted while one is in flight; rsp_tvalid rises at present.
// The quarter-wave table memory has one read port and the single multiplier
// is reused each frame.
// Reset: the settings registers return to their defaults, phase to zero, and
// the table is loaded into memory with req_tready low until loading is done.
// A stalled rsp word holds its value and the block waits.
module clipped_sine_tone_generator #(
   parameter int SINE_TABLE_DEPTH = cstg_pkg::SINE_TABLE_DEPTH_DEFAULT,
   parameter int PHASE_BITS       = cstg_pkg::PHASE_BITS_DEFAULT,
   parameter int MAX_BLOCK_FRAMES = cstg_pkg::MAX_BLOCK_FRAMES_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // frames_requested[6:0], zero [7]
   input  logic        req_tuser,   // restart
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // sample[15:0]
   output logic        rsp_tlast,
   output logic [1:0]  rsp_tuser,   // silent_pad[0], stream_complete[1]
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_data
);
   import cstg_pkg::*;

   localparam int CountBits = $clog2(MAX_BLOCK_FRAMES + 1);

   cstg_state_type        state_ff;
   cstg_state_type        state_in;
   logic [PHASE_BITS-1:0] phase_ff;
   logic [PHASE_BITS-1:0] phase_in;
   logic [23:0]           frames_left_ff;
   logic [23:0]           frames_left_in;
   logic [CountBits-1:0]  remain_ff;
   logic [CountBits-1:0]  remain_in;

   logic [31:0] inc_ff;
   logic [16:0] gain_ff;
   logic [14:0] clip_ff;
   logic [23:0] total_ff;

   logic [15:0] sample_ff;
   logic [15:0] sample_in;
   logic        pad_ff;
   logic        pad_in;
   logic        last_ff;
   logic        last_in;
   logic        complete_ff;
   logic        complete_in;

   logic          fill_done;
   logic          rd_en;
   logic          mul_en;
   cstg_sine_type sine;
   logic [15:0]   shaped;
   logic [6:0]    req_count;
   logic          last_frame;

   cstg_sine #(
      .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
      .PHASE_BITS       (PHASE_BITS)
   ) u_sine (
      .clock     (clock),
      .reset     (reset),
      .phase     (phase_ff),
      .rd_en     (rd_en),
      .fill_done (fill_done),
      .sine      (sine)
   );

   cstg_scale u_scale (
      .clock      (clock),
      .mul_en     (mul_en),
      .sine       (sine),
      .gain       (gain_ff),
      .clip_limit (clip_ff),
      .sample     (shaped)
   );

   assign req_count  = (req_tdata[6:0] > 7'(MAX_BLOCK_FRAMES)) ?
                       7'(MAX_BLOCK_FRAMES) : req_tdata[6:0];
   assign last_frame = (remain_ff == CountBits'(1));

   always_comb begin
      state_in       = state_ff;
      phase_in       = phase_ff;
      frames_left_in = frames_left_ff;
      remain_in      = remain_ff;
      sample_in      = sample_ff;
      pad_in         = pad_ff;
      last_in        = last_ff;
      complete_in    = complete_ff;
      rd_en          = 1'b0;
      mul_en         = 1'b0;
      unique case (state_ff)
         ST_FILL: begin
            if (fill_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_tvalid) begin
               if (req_tuser) begin
                  phase_in       = '0;
                  frames_left_in = total_ff;
               end
               remain_in = CountBits'(req_count);
               if (req_count != 7'd0) begin
                  state_in = ST_NEXT;
               end
            end
         end
         ST_NEXT: begin
            if (frames_left_ff == 24'd0) begin
               sample_in   = 16'd0;
               pad_in      = 1'b1;
               last_in     = last_frame;
               complete_in = last_frame;
               state_in    = ST_EMIT;
            end else begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            rd_en    = 1'b1;
            state_in = ST_SCALE;
         end
         ST_SCALE: begin
            mul_en   = 1'b1;
            state_in = ST_SHAPE;
         end
         ST_SHAPE: begin
            sample_in      = shaped;
            pad_in         = 1'b0;
            last_in        = last_frame;
            complete_in    = last_frame && (frames_left_ff == 24'd1);
            phase_in       = phase_ff + PHASE_BITS'(inc_ff);
            frames_left_in = frames_left_ff - 24'd1;
            state_in       = ST_EMIT;
         end
         ST_EMIT: begin
            if (rsp_tready) begin
               remain_in = remain_ff - 1'b1;
               state_in  = last_frame ? ST_IDLE : ST_NEXT;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_FILL;
         phase_ff       <= '0;
         frames_left_ff <= TOTAL_FRAMES_RESET;
         remain_ff      <= '0;
      end else begin
         state_ff       <= state_in;
         phase_ff       <= phase_in;
         frames_left_ff <= frames_left_in;
         remain_ff      <= remain_in;
      end
   end

   always_ff @(posedge clock) begin
      sample_ff   <= sample_in;
      pad_ff      <= pad_in;
      last_ff     <= last_in;
      complete_ff <= complete_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inc_ff   <= PHASE_INCREMENT_RESET;
         gain_ff  <= GAIN_RESET;
         clip_ff  <= CLIP_LIMIT_RESET;
         total_ff <= TOTAL_FRAMES_RESET;
      end else if (csr_valid) begin
         unique case (cstg_csr_type'(csr_index))
            CSR_PHASE_INCREMENT: inc_ff   <= csr_data;
            CSR_GAIN:            gain_ff  <= csr_data[16:0];
            CSR_CLIP_LIMIT:      clip_ff  <= csr_data[14:0];
            CSR_TOTAL_FRAMES:    total_ff <= csr_data[23:0];
            default:             inc_ff   <= inc_ff;
         endcase
      end
   end

   assign csr_ready  = 1'b1;
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = (state_ff == ST_EMIT);
   assign rsp_tdata  = sample_ff;
   assign rsp_tlast  = last_ff;
   assign rsp_tuser  = {complete_ff, pad_ff};

endmodule

// ----- sv/cstg_checker.sv -----
module cstg_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [7:0]  req_tdata,
   input logic        req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata,
   input logic        rsp_tlast,
   input logic [1:0]  rsp_tuser,
   input logic        csr_valid,
   input logic        csr_ready,
   input logic [1:0]  csr_index,
   input logic [31:0] csr_data
);

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && !req_tready)
      else $error("outputs active right after reset");

   a_one_side: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("request taken while a frame is pending");

   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata == 16'd0)
      else $error("padding frame with nonzero sample");

   a_complete_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |-> rsp_tlast)
      else $error("stream end flagged off the last frame");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tlast) && $stable(rsp_tuser))
      else $error("stalled frame changed");

endmodule

bind clipped_sine_tone_generator cstg_checker u_cstg_checker (.*);

// ----- test/clipped_sine_tone_checker.sv -----
`timescale 1ns / 100ps

module clipped_sine_tone_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,   // frames_requested[6:0], zero [7]
   input  logic        req_tuser,   // restart
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [15:0] rsp_tdata,   // sample[15:0]
   input  logic        rsp_tlast,
   input  logic [1:0]  rsp_tuser,   // silent_pad[0], stream_complete[1]
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_data,
   output int          fail_count,
   output int          frames_due
);
   import cstg_pkg::*;

   localparam int TABLE_DEPTH = SINE_TABLE_DEPTH_DEFAULT;
   localparam int BLOCK_MAX   = MAX_BLOCK_FRAMES_DEFAULT;

   typedef struct packed {
      logic [15:0] sample;
      logic        silent_pad;
      logic        last_of_block;
      logic        stream_complete;
   } tone_frame_type;

   logic [14:0] quarter_tab [0:TABLE_DEPTH-1];

   logic [31:0] inc_reg;
   logic [16:0] gain_reg;
   logic [14:0] clip_reg;
   logic [23:0] total_reg;
   logic [31:0] phase_acc;
   logic [23:0] tone_left;

   tone_frame_type expected_frames [$];
   tone_frame_type want;

   function automatic logic [14:0] series_sine(input int unsigned k);
      logic [63:0]        ang;
      logic [63:0]        ang_sq;
      logic [63:0]        term;
      logic [63:0]        rounded;
      logic signed [63:0] acc;
      int                 n;
      ang    = (64'(k) * HALF_PI_Q30) / 64'(TABLE_DEPTH);
      ang_sq = (ang * ang) >> 30;
      term   = ang;
      acc    = $signed(ang);
      for (n = 1; n <= 5; n++) begin
         term = ((term * ang_sq) >> 30) / 64'(2 * n * (2 * n + 1));
         if (n % 2 == 1) begin
            acc = acc - $signed(term);
         end else begin
            acc = acc + $signed(term);
         end
      end
      if (acc < 0) begin
         acc = 64'sd0;
      end
      rounded = ($unsigned(acc) * 64'(FULL_SCALE) + (64'd1 << 29)) >> 30;
      if (rounded > 64'(FULL_SCALE)) begin
         rounded = 64'(FULL_SCALE);
      end
      return rounded[14:0];
   endfunction

   function automatic logic [15:0] tone_sample(input logic [31:0] ph);
      logic [1:0]  quad;
      logic [9:0]  idx;
      logic [14:0] mag;
      logic [31:0] scaled;
      quad = ph[31:30];
      idx  = ph[29:20];
      if (quad[0]) begin
         mag = (idx == 10'd0) ? FULL_SCALE : quarter_tab[10'(11'd1024 - 11'(idx))];
      end else begin
         mag = quarter_tab[idx];
      end
      scaled = (32'(mag) * 32'(gain_reg)) >> 16;
      if (scaled > 32'(clip_reg)) begin
         scaled = 32'(clip_reg);
      end
      return quad[1] ? 16'(-scaled[15:0]) : scaled[15:0];
   endfunction

   task automatic synthesize_block(input logic [6:0] requested, input logic restart);
      int unsigned    frames;
      int unsigned    i;
      tone_frame_type f;
      if (restart) begin
         phase_acc = '0;
         tone_left = total_reg;
      end
      frames = (requested > BLOCK_MAX) ? BLOCK_MAX : requested;
      for (i = 0; i < frames; i++) begin
         if (tone_left == 24'd0) begin
            f.sample     = '0;
            f.silent_pad = 1'b1;
         end else begin
            f.sample     = tone_sample(phase_acc);
            f.silent_pad = 1'b0;
            phase_acc    = phase_acc + inc_reg;
            tone_left    = tone_left - 24'd1;
         end
         f.last_of_block   = (i + 1 == frames);
         f.stream_complete = f.last_of_block && (tone_left == 24'd0);
         expected_frames.push_back(f);
      end
   endtask

   task automatic report(input string field, input int expected_val, input int actual_val);
      $display("%0t: %s mismatch, expected %0d, actual %0d",
               $time, field, expected_val, actual_val);
      fail_count++;
   endtask

   initial begin
      fail_count = 0;
      frames_due = 0;
      for (int unsigned k = 0; k < TABLE_DEPTH; k++) begin
         quarter_tab[k] = series_sine(k);
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         inc_reg   = PHASE_INCREMENT_RESET;
         gain_reg  = GAIN_RESET;
         clip_reg  = CLIP_LIMIT_RESET;
         total_reg = TOTAL_FRAMES_RESET;
         phase_acc = '0;
         tone_left = TOTAL_FRAMES_RESET;
         expected_frames.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_frames.size() == 0) begin
               $display("%0t: unexpected word, expected none, actual %0d %0b %b",
                        $time, $signed(rsp_tdata), rsp_tlast, rsp_tuser);
               fail_count++;
            end else begin
               want = expected_frames.pop_front();
               if (rsp_tdata !== want.sample) begin
                  report("sample", $signed(want.sample), $signed(rsp_tdata));
               end
               if (rsp_tuser[0] !== want.silent_pad) begin
                  report("silent_pad", want.silent_pad, rsp_tuser[0]);
               end
               if (rsp_tlast !== want.last_of_block) begin
                  report("last_of_block", want.last_of_block, rsp_tlast);
               end
               if (rsp_tuser[1] !== want.stream_complete) begin
                  report("stream_complete", want.stream_complete, rsp_tuser[1]);
               end
            end
         end
         if (csr_valid && csr_ready) begin
            case (cstg_csr_type'(csr_index))
               CSR_PHASE_INCREMENT: inc_reg   = csr_data;
               CSR_GAIN:            gain_reg  = csr_data[16:0];
               CSR_CLIP_LIMIT:      clip_reg  = csr_data[14:0];
               CSR_TOTAL_FRAMES:    total_reg = csr_data[23:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            synthesize_block(req_tdata[6:0], req_tuser);
         end
      end
      frames_due <= expected_frames.size();
   end

endmodule

// ----- test/tb_clipped_sine_tone_generator.sv -----
`timescale 1ns / 100ps

module tb_clipped_sine_tone_generator;
   import cstg_pkg::*;

   localparam int CYCLE_LIMIT = 600000;
   localparam int SETTLE      = 20;

   logic        clock;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = '0;
   logic        req_tuser  = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic        rsp_tlast;
   logic [1:0]  rsp_tuser;
   logic        csr_valid  = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index  = '0;
   logic [31:0] csr_data   = '0;

   int fail_count;
   int frames_due;
   int cycles      = 0;
   int req_idle_pct = 0;
   int rsp_idle_pct = 0;

   clipped_sine_tone_generator uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   clipped_sine_tone_checker tone_check (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .fail_count (fail_count),
      .frames_due (frames_due)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("clipped_sine_tone_generator regression: fail");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   task automatic write_csr(input cstg_csr_type which, input logic [31:0] value);
      csr_valid <= 1'b1;
      csr_index <= which;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic load_settings(input logic [31:0] inc, input logic [16:0] gain,
                                input logic [14:0] clip, input logic [23:0] total);
      write_csr(CSR_PHASE_INCREMENT, inc);
      write_csr(CSR_GAIN, 32'(gain));
      write_csr(CSR_CLIP_LIMIT, 32'(clip));
      write_csr(CSR_TOTAL_FRAMES, 32'(total));
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_block(input logic [6:0] frames, input logic restart);
      while ($urandom_range(99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {1'b0, frames};
      req_tuser  <= restart;
      do @(posedge clock); while (!req_tready);
   endtask

   // hold off until every frame is out, then let the block settle
   task automatic wait_quiet();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (frames_due != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic random_settings();
      logic [31:0] inc;
      logic [16:0] gain;
      logic [14:0] clip;
      logic [23:0] total;
      case ($urandom_range(3))
         0: inc = $urandom;
         1: inc = $urandom_range(1 << 24);
         2: inc = 32'hFFFF_FFFF - $urandom_range(1 << 20);
         default: inc = 32'd1 << $urandom_range(31);
      endcase
      case ($urandom_range(3))
         0: gain = 17'd65536;
         1: gain = 17'($urandom_range(131071));
         default: gain = 17'($urandom_range(65536));
      endcase
      case ($urandom_range(3))
         0: clip = 15'd32767;
         1: clip = 15'($urandom_range(64));
         default: clip = 15'($urandom_range(32767));
      endcase
      case ($urandom_range(3))
         0: total = 24'($urandom_range(40));
         1: total = 24'($urandom_range(300));
         2: total = 24'($urandom_range(2000));
         default: total = 24'hFF_FFFF - 24'($urandom_range(1000));
      endcase
      load_settings(inc, gain, clip, total);
   endtask

   task automatic random_block();
      logic [6:0] frames;
      case ($urandom_range(19))
         0:        frames = 7'd0;
         1:        frames = 7'($urandom_range(127, 65));
         2, 3, 4:  frames = 7'($urandom_range(64, 17));
         default:  frames = 7'($urandom_range(16, 1));
      endcase
      send_block(frames, $urandom_range(7) == 0);
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      do @(posedge clock); while (!req_tready);

      req_idle_pct = 14;
      rsp_idle_pct = 46;
      send_block(7'd1, 1'b0);
      send_block(7'd64, 1'b0);
      send_block(7'd127, 1'b0);
      send_block(7'd0, 1'b0);
      send_block(7'd3, 1'b1);
      send_block(7'd0, 1'b1);
      send_block(7'd2, 1'b0);
      wait_quiet();

      load_settings(32'hFFFF_FFFF, 17'h1FFFF, 15'd32767, 24'd10);
      send_block(7'd4, 1'b1);
      send_block(7'd8, 1'b0);
      send_block(7'd5, 1'b0);
      wait_quiet();

      load_settings(32'h4000_0000, 17'd65536, 15'd32767, 24'hFF_FFFF);
      send_block(7'd9, 1'b1);
      wait_quiet();

      load_settings(32'h0010_0000, 17'd65536, 15'd0, 24'd0);
      send_block(7'd6, 1'b1);
      wait_quiet();

      load_settings(32'h0010_0000, 17'd0, 15'd32767, 24'd100);
      send_block(7'd3, 1'b1);
      send_block(7'd7, 1'b0);
      wait_quiet();

      for (int stage = 0; stage < 3; stage++) begin
         case (stage)
            0: begin
               req_idle_pct = 14;
               rsp_idle_pct = 46;
            end
            1: begin
               req_idle_pct = 46;
               rsp_idle_pct = 14;
            end
            default: begin
               req_idle_pct = 0;
               rsp_idle_pct = 0;
            end
         endcase
         for (int seg = 0; seg < 3; seg++) begin
            wait_quiet();
            random_settings();
            send_block(7'($urandom_range(16, 1)), 1'b1);
            for (int n = 0; n < 39; n++) begin
               random_block();
            end
         end
      end

      wait_quiet();
      if (fail_count == 0) begin
         $display("clipped_sine_tone_generator regression: pass");
      end else begin
         $display("clipped_sine_tone_generator regression: fail");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
sv/cstg_pkg.sv
sv/cstg_ram.sv
sv/cstg_sine.sv
sv/cstg_scale.sv
sv/clipped_sine_tone_generator.sv
sv/cstg_checker.sv
test/clipped_sine_tone_checker.sv
test/tb_clipped_sine_tone_generator.sv
